/* design/kirr_pkg.sv */
// package for the knock interval recorder: sizes, register defaults, codes and state type
`default_nettype none
package kirr_pkg;

	localparam int MAX_KNOCKS = 10;
	localparam int IDX_W      = (MAX_KNOCKS > 1) ? $clog2(MAX_KNOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_KNOCKS + 1);
	localparam int TICK_W     = 13;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam int LONG_W  = 12;
	localparam int SHORT_W = 8;
	localparam int KNOCKS_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [LONG_W-1:0]  IDLE_RESET = 12'd1500;
	localparam logic [LONG_W-1:0]  COOL_RESET = 12'd500;
	localparam logic [SHORT_W-1:0] ON_RESET   = 8'd50;
	localparam logic [SHORT_W-1:0] OFF_RESET  = 8'd150;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IDLE = 2'd0,
		REG_COOL = 2'd1,
		REG_ON   = 2'd2,
		REG_OFF  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_REC,
		ST_GAP,
		ST_ON,
		ST_OFF,
		ST_COOL
	} state_t;

	localparam logic [1:0] PHASE_WAIT = 2'd0;
	localparam logic [1:0] PHASE_REC  = 2'd1;
	localparam logic [1:0] PHASE_PLAY = 2'd2;
	localparam logic [1:0] PHASE_COOL = 2'd3;

endpackage
`default_nettype wire

/* design/kirr_ram.sv */
// interval store: one write port, one registered read port with write forwarding
`default_nettype none
module kirr_ram #(
	parameter int DEPTH = 10,
	parameter int WIDTH = 13,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// same-entry write and read in one cycle returns the new value
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* design/knock_interval_record_replay.sv */
// top level of the knock interval recorder and replayer
`default_nettype none
// Usage:
// one input item per millisecond tick carries pin_level (0 = knock pressed).
// every accepted item yields exactly one result item (led_on, phase,
// knocks_stored) showing the state after that tick.
// the result is registered and is valid in the cycle after the item is accepted.
// throughput: one item per cycle while the receiver is not stalling; the tick
// update, the interval store read (address issued with the update) and the
// output register all keep up with that rate.
// in_ready is high whenever the output register is empty or being taken,
// so a stalled receiver holds the result and stops intake one item later.
// the configuration channel is always ready and writes one of four
// timing registers per handshake; it is meant to be used while idle.
// reset (arst_n low) returns to waiting with an empty store and the
// default timings; the store contents themselves are not cleared.
module knock_interval_record_replay
	import kirr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 pin_level,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      led_on,
	output logic [1:0]                phase,
	output logic [KNOCKS_W-1:0]       knocks_stored,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LONG_W-1:0]    cfg_data
);

	logic [LONG_W-1:0]  idle_q, cool_q;
	logic [SHORT_W-1:0] on_q, off_q;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d, count_rec;
	logic [IDX_W-1:0]   replay_q, replay_d, rd_addr, wr_addr, srch_idx;
	logic [TICK_W-1:0]  tick_q, tick_d, t, wr_data, rd_data;
	logic               last_q, last_d;
	logic [MAX_KNOCKS-1:0] nz_q, nz_eff;

	logic               in_acc, pressed, rise, store_ok, rec_store, wr_raw, wr_en;
	logic               skip, srch_found, rec_done;
	logic [CNT_W-1:0]   srch_start;
	state_t             srch_state, cool_state, off_state, on_state;

	logic               out_valid_q, led_q;
	logic [1:0]         phase_q;
	logic [KNOCKS_W-1:0] knocks_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= IDLE_RESET;
			cool_q <= COOL_RESET;
			on_q   <= ON_RESET;
			off_q  <= OFF_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IDLE: idle_q <= cfg_data;
				REG_COOL: cool_q <= cfg_data;
				REG_ON:   on_q   <= cfg_data[SHORT_W-1:0];
				REG_OFF:  off_q  <= cfg_data[SHORT_W-1:0];
				default: ;
			endcase
		end
	end

	// tick and knock detection
	assign t         = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
	assign pressed   = ~pin_level;
	assign rise      = pressed && !last_q;
	assign store_ok  = count_q < CNT_W'(MAX_KNOCKS);
	assign rec_store = (state_q == ST_REC) && rise && store_ok;
	assign count_rec = count_q + CNT_W'(rec_store);

	assign wr_raw  = ((state_q == ST_WAIT) && rise) || rec_store;
	assign wr_en   = wr_raw && in_acc;
	assign wr_addr = (state_q == ST_WAIT) ? '0 : count_q[IDX_W-1:0];
	assign wr_data = (state_q == ST_WAIT) ? '0 : t;

	// nonzero flags including the entry written this tick
	always_comb begin
		for (int i = 0; i < MAX_KNOCKS; i++) begin
			if (wr_raw && (wr_addr == IDX_W'(i))) begin
				nz_eff[i] = (wr_data != '0);
			end else begin
				nz_eff[i] = nz_q[i];
			end
		end
	end

	// next replay entry; with both blink lengths zero, zero intervals are skipped
	assign skip       = (on_q == '0) && (off_q == '0);
	assign srch_start = (state_q == ST_REC) ? '0 : CNT_W'({1'b0, replay_q} + 1'b1);

	always_comb begin
		srch_found = 1'b0;
		srch_idx   = '0;
		for (int i = MAX_KNOCKS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) >= srch_start) && (CNT_W'(i) < count_rec)
					&& (nz_eff[i] || !skip)) begin
				srch_found = 1'b1;
				srch_idx   = IDX_W'(i);
			end
		end
	end

	assign cool_state = (cool_q == '0) ? ST_WAIT : ST_COOL;
	assign off_state  = (off_q != '0) ? ST_OFF : srch_state;
	assign on_state   = (on_q != '0) ? ST_ON : off_state;

	always_comb begin
		if (!srch_found) begin
			srch_state = cool_state;
		end else if (nz_eff[srch_idx]) begin
			srch_state = ST_GAP;
		end else if (on_q != '0) begin
			srch_state = ST_ON;
		end else begin
			srch_state = ST_OFF;
		end
	end

	assign rec_done = ({1'b0, idle_q} < t)
		|| (rise && (!store_ok || (count_rec >= CNT_W'(MAX_KNOCKS))));

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		replay_d = replay_q;
		tick_d   = t;
		last_d   = last_q;
		unique case (state_q)
			ST_WAIT: begin
				last_d  = pressed;
				tick_d  = '0;
				count_d = '0;
				if (rise) begin
					count_d = CNT_W'(1);
					state_d = ST_REC;
				end
			end
			ST_REC: begin
				last_d  = pressed;
				count_d = count_rec;
				if (rise) begin
					tick_d = '0;
				end
				if (rec_done) begin
					tick_d  = '0;
					state_d = srch_state;
					if (srch_found) begin
						replay_d = srch_idx;
					end else begin
						count_d = '0;
					end
				end
			end
			ST_GAP: begin
				if (t >= rd_data) begin
					tick_d  = '0;
					state_d = on_state;
					if ((on_q == '0) && (off_q == '0)) begin
						if (srch_found) begin
							replay_d = srch_idx;
						end else begin
							count_d = '0;
						end
					end
				end
			end
			ST_ON: begin
				if (t >= {5'd0, on_q}) begin
					tick_d  = '0;
					state_d = off_state;
					if (off_q == '0) begin
						if (srch_found) begin
							replay_d = srch_idx;
						end else begin
							count_d = '0;
						end
					end
				end
			end
			ST_OFF: begin
				if (t >= {5'd0, off_q}) begin
					tick_d  = '0;
					state_d = srch_state;
					if (srch_found) begin
						replay_d = srch_idx;
					end else begin
						count_d = '0;
					end
				end
			end
			ST_COOL: begin
				if (t >= {1'b0, cool_q}) begin
					tick_d  = '0;
					count_d = '0;
					state_d = ST_WAIT;
				end
			end
			default: begin
				tick_d  = '0;
				count_d = '0;
				state_d = ST_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WAIT;
			count_q  <= '0;
			replay_q <= '0;
			tick_q   <= '0;
			last_q   <= 1'b0;
		end else if (in_acc) begin
			state_q  <= state_d;
			count_q  <= count_d;
			replay_q <= replay_d;
			tick_q   <= tick_d;
			last_q   <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			nz_q <= nz_eff;
		end
	end

	// read address follows the replay index so rd_data always holds its interval
	assign rd_addr = in_acc ? replay_d : replay_q;

	kirr_ram #(
		.DEPTH (MAX_KNOCKS),
		.WIDTH (TICK_W),
		.AW    (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			led_q    <= (state_d == ST_ON);
			knocks_q <= KNOCKS_W'(count_d);
			unique case (state_d)
				ST_WAIT: phase_q <= PHASE_WAIT;
				ST_REC:  phase_q <= PHASE_REC;
				ST_COOL: phase_q <= PHASE_COOL;
				default: phase_q <= PHASE_PLAY;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign led_on        = led_q;
	assign phase         = phase_q;
	assign knocks_stored = knocks_q;

	a_rec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REC) |-> (count_q != '0))
		else $error("recording with an empty store");

	a_replay_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_GAP) || (state_q == ST_ON) || (state_q == ST_OFF))
			|-> ({1'b0, replay_q} < {1'b0, count_q}))
		else $error("replay index beyond stored entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KNOCKS))
		else $error("store count above capacity");

	a_led_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && led_q) |-> (phase_q == PHASE_PLAY))
		else $error("led lit outside replay");

	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (state_d == ST_GAP) && (state_q != ST_GAP)) |=> (rd_data != '0))
		else $error("interval wait entered on a zero interval");

endmodule
`default_nettype wire
